FILE: hdl/gmrm_pkg.sv
package gmrm_pkg;

	localparam int MAX_EDGES_DEF    = 256;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_ROUNDS_DEF   = 8;
	localparam int WEIGHT_BITS_DEF  = 32;

	localparam int SUM_W = 40;
	localparam int OUT_SUM_W = 39;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_IDX  = 2'd2;

endpackage

FILE: hdl/gmrm_ram.sv
module gmrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/greedy_multi_round_matching_top.sv
// Operations: load stores an edge, read returns an edge's round (or an index error when the
// index is past the count), clear sweeps max(MAX_EDGES, MAX_VERTICES) entries; run does the same sweep,
// a stable insertion sort by descending weight, then a greedy walk over the sorted edges per round.
// Throughput: one word in flight; s_tready stays low until the result word is taken.
// Reset (arst_n low) empties the edge store, zeroes the total, sets rounds to
// 1 and runs a clearing sweep over round and busy memories before first input.
module greedy_multi_round_matching_top #(
	parameter int MAX_EDGES    = gmrm_pkg::MAX_EDGES_DEF,
	parameter int MAX_VERTICES = gmrm_pkg::MAX_VERTICES_DEF,
	parameter int MAX_ROUNDS   = gmrm_pkg::MAX_ROUNDS_DEF,
	parameter int WEIGHT_BITS  = gmrm_pkg::WEIGHT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[1:0], first_vertex[7:2], second_vertex[13:8], edge_weight[45:14],
	// edge_index[53:46], zero fill to 56
	input  logic [55:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], edge_round[5:2], total_weight[44:6], zero fill to 48
	output logic [47:0]  m_tdata
);

	localparam int EW = $clog2(MAX_EDGES);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int SW = gmrm_pkg::SUM_W;
	localparam int CLR_N = (MAX_EDGES > MAX_VERTICES) ? MAX_EDGES : MAX_VERTICES;
	localparam int CLW = $clog2(CLR_N + 1);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_READ1, S_READ2, S_SRT_I, S_SRT_I2, S_SRT_J, S_SRT_J2,
		S_SRT_CMP, S_SRT_PUT, S_RND, S_WLK_A, S_WLK_B, S_WLK_C, S_WLK_E, S_WLK_D,
		S_WLK_G, S_OUT
	} state_t;

	// where the clearing sweep goes when done
	typedef enum logic [1:0] {
		NX_IDLE, NX_OUT, NX_SORT
	} sweep_t;

	state_t state_q;
	sweep_t sweep_q;
	logic [3:0] rounds_cfg_q;
	logic [CW-1:0] count_q, n_q, i_q, j_q;
	logic [CLW-1:0] clr_q;
	logic [SW-1:0] sum_q;
	logic [RW-1:0] r_q, rlim_q;
	logic [1:0] st_q;
	logic [RW-1:0] ro_q;
	logic [EW-1:0] e_q;
	logic signed [WEIGHT_BITS-1:0] wi_q;
	logic [EW-1:0] ival_q;

	// edge store memories
	logic ed_we;
	logic [EW-1:0] ed_waddr, ed_raddr;
	logic [VW-1:0] f_rd, s_rd;
	logic [WEIGHT_BITS-1:0] w_rd;
	logic [EW-1:0] ord_waddr, ord_raddr, ord_rd, ord_wdata;
	logic ord_we;
	logic [RW-1:0] rnd_rd, rnd_wdata;
	logic [EW-1:0] rnd_waddr, rnd_raddr;
	logic rnd_we;
	logic [VW-1:0] bs_waddr, bs_raddr;
	logic [MAX_ROUNDS-1:0] bs_wdata, bs_rd;
	logic bs_we;
	logic [MAX_ROUNDS-1:0] bs_s_q;
	logic [VW-1:0] vs_q, vt_q;

	logic [1:0] op;
	logic [VW-1:0] in_f, in_s;
	logic [WEIGHT_BITS-1:0] in_w;
	logic [7:0] in_idx;
	assign op = s_tdata[1:0];
	assign in_f = VW'(s_tdata[7:2]);
	assign in_s = VW'(s_tdata[13:8]);
	assign in_w = WEIGHT_BITS'(s_tdata[45:14]);
	assign in_idx = s_tdata[53:46];

	logic acc;
	assign s_tready = (state_q == S_IDLE);
	assign acc = s_tvalid && s_tready;

	gmrm_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_first (.clk(clk), .we(ed_we),
		.waddr(ed_waddr), .wdata(in_f), .raddr(ed_raddr), .rdata(f_rd));
	gmrm_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_second (.clk(clk), .we(ed_we),
		.waddr(ed_waddr), .wdata(in_s), .raddr(ed_raddr), .rdata(s_rd));
	gmrm_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_EDGES)) u_wt (.clk(clk), .we(ed_we),
		.waddr(ed_waddr), .wdata(in_w), .raddr(ed_raddr), .rdata(w_rd));
	gmrm_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_ord (.clk(clk), .we(ord_we),
		.waddr(ord_waddr), .wdata(ord_wdata), .raddr(ord_raddr), .rdata(ord_rd));
	gmrm_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_rnd (.clk(clk), .we(rnd_we),
		.waddr(rnd_waddr), .wdata(rnd_wdata), .raddr(rnd_raddr), .rdata(rnd_rd));
	gmrm_ram #(.WIDTH(MAX_ROUNDS), .DEPTH(MAX_VERTICES)) u_busy (.clk(clk),
		.we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata), .raddr(bs_raddr),
		.rdata(bs_rd));

	logic [MAX_ROUNDS-1:0] rbit;
	assign rbit = MAX_ROUNDS'(1) << r_q;

	// edge still open and both endpoints free in this round
	logic take_d;
	assign take_d = rnd_rd == RW'(MAX_ROUNDS) && (bs_s_q & rbit) == '0
		&& (bs_rd & rbit) == '0;

	// memory port control
	always_comb begin
		ed_we = acc && op == gmrm_pkg::OP_LOAD && count_q < CW'(MAX_EDGES);
		ed_waddr = count_q[EW-1:0];
		ed_raddr = e_q;
		ord_we = 1'b0;
		ord_waddr = j_q[EW-1:0];
		ord_wdata = ord_rd;
		ord_raddr = j_q[EW-1:0] - EW'(1);
		rnd_we = 1'b0;
		rnd_waddr = e_q;
		rnd_wdata = RW'(MAX_ROUNDS);
		rnd_raddr = e_q;
		bs_we = 1'b0;
		bs_waddr = clr_q[VW-1:0];
		bs_wdata = '0;
		bs_raddr = vs_q;
		if (ed_we) begin
			rnd_we = 1'b1;
			rnd_waddr = count_q[EW-1:0];
		end
		case (state_q)
			S_CLR: begin
				rnd_we = clr_q < CLW'(MAX_EDGES);
				rnd_waddr = clr_q[EW-1:0];
				bs_we = clr_q < CLW'(MAX_VERTICES);
			end
			S_SRT_I: ed_raddr = i_q[EW-1:0];
			S_SRT_J2: ed_raddr = ord_rd;
			S_SRT_CMP: begin
				// shift order[j-1] up into slot j
				ord_we = $signed(w_rd) < wi_q;
			end
			S_SRT_PUT: begin
				ord_we = 1'b1;
				ord_wdata = ival_q;
			end
			S_WLK_A: ord_raddr = j_q[EW-1:0];
			S_WLK_B: begin
				ed_raddr = ord_rd;
				rnd_raddr = ord_rd;
			end
			S_WLK_C: bs_raddr = f_rd;
			S_WLK_E: bs_raddr = vt_q;
			S_WLK_D: begin
				if (take_d) begin
					rnd_we = 1'b1;
					rnd_wdata = r_q;
					bs_we = 1'b1;
					bs_waddr = vt_q;
					bs_wdata = bs_rd | rbit;
				end
			end
			S_WLK_G: begin
				bs_we = 1'b1;
				bs_waddr = vs_q;
				bs_wdata = bs_s_q | rbit;
			end
			S_READ1: rnd_raddr = e_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sweep_q <= NX_IDLE;
			rounds_cfg_q <= 4'd1;
			count_q <= '0;
			clr_q <= '0;
			sum_q <= '0;
			n_q <= '0; i_q <= '0; j_q <= '0;
			r_q <= '0; rlim_q <= '0;
			st_q <= '0; ro_q <= '0; e_q <= '0;
			wi_q <= '0; ival_q <= '0; bs_s_q <= '0; vs_q <= '0; vt_q <= '0;
		end else begin
			if (cfg_we) begin
				rounds_cfg_q <= cfg_wdata;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q >= CLW'(MAX_EDGES) && clr_q >= CLW'(MAX_VERTICES)) begin
						st_q <= gmrm_pkg::ST_OK;
						ro_q <= '0;
						case (sweep_q)
							NX_SORT: begin
								i_q <= '0;
								n_q <= '0;
								state_q <= S_SRT_I;
							end
							NX_OUT: state_q <= S_OUT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_IDLE: begin
					if (acc) begin
						st_q <= gmrm_pkg::ST_OK;
						ro_q <= '0;
						state_q <= S_OUT;
						case (op)
							gmrm_pkg::OP_LOAD: begin
								if (count_q < CW'(MAX_EDGES)) count_q <= count_q + 1'b1;
								else st_q <= gmrm_pkg::ST_FULL;
							end
							gmrm_pkg::OP_RUN: begin
								sum_q <= '0;
								clr_q <= '0;
								sweep_q <= NX_SORT;
								state_q <= S_CLR;
							end
							gmrm_pkg::OP_READ: begin
								if (32'(in_idx) >= 32'(count_q)
								    || 32'(in_idx) >= 32'(MAX_EDGES)) begin
									st_q <= gmrm_pkg::ST_IDX;
									ro_q <= RW'(MAX_ROUNDS);
								end else begin
									e_q <= EW'(in_idx);
									state_q <= S_READ1;
								end
							end
							default: begin
								count_q <= '0;
								sum_q <= '0;
								clr_q <= '0;
								sweep_q <= NX_OUT;
								state_q <= S_CLR;
							end
						endcase
					end
				end
				S_READ1: state_q <= S_READ2;
				S_READ2: begin
					ro_q <= rnd_rd;
					state_q <= S_OUT;
				end
				S_SRT_I: begin
					if (i_q >= count_q) begin
						r_q <= '0;
						rlim_q <= (int'(rounds_cfg_q) > MAX_ROUNDS) ? RW'(MAX_ROUNDS)
							: RW'(rounds_cfg_q);
						state_q <= S_RND;
					end else begin
						ival_q <= i_q[EW-1:0];
						state_q <= S_SRT_I2;
					end
				end
				S_SRT_I2: begin
					wi_q <= $signed(w_rd);
					i_q <= i_q + 1'b1;
					if ($signed(w_rd) > 0) begin
						j_q <= n_q;
						state_q <= S_SRT_J;
					end else begin
						state_q <= S_SRT_I;
					end
				end
				S_SRT_J: begin
					// read of order[j-1] issued here
					if (j_q == '0) state_q <= S_SRT_PUT;
					else state_q <= S_SRT_J2;
				end
				S_SRT_J2: state_q <= S_SRT_CMP;
				S_SRT_CMP: begin
					if ($signed(w_rd) < wi_q) begin
						j_q <= j_q - 1'b1;
						state_q <= S_SRT_J;
					end else begin
						state_q <= S_SRT_PUT;
					end
				end
				S_SRT_PUT: begin
					n_q <= n_q + 1'b1;
					state_q <= S_SRT_I;
				end
				S_RND: begin
					j_q <= '0;
					if (r_q >= rlim_q) state_q <= S_OUT;
					else state_q <= S_WLK_A;
				end
				S_WLK_A: begin
					if (j_q >= n_q) begin
						r_q <= r_q + 1'b1;
						state_q <= S_RND;
					end else begin
						state_q <= S_WLK_B;
					end
				end
				S_WLK_B: begin
					e_q <= ord_rd;
					state_q <= S_WLK_C;
				end
				S_WLK_C: begin
					vs_q <= f_rd;
					vt_q <= s_rd;
					state_q <= S_WLK_E;
				end
				S_WLK_E: begin
					bs_s_q <= bs_rd;
					state_q <= S_WLK_D;
				end
				S_WLK_D: begin
					if (take_d) begin
						sum_q <= sum_q + SW'($signed(w_rd));
						state_q <= S_WLK_G;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_WLK_A;
					end
				end
				S_WLK_G: begin
					j_q <= j_q + 1'b1;
					state_q <= S_WLK_A;
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {3'd0, sum_q[gmrm_pkg::OUT_SUM_W-1:0], 4'(ro_q), st_q};

endmodule
